// ===== rtl/rvm_pkg.sv =====
package rvm_pkg;

   typedef enum logic [3:0] {
      OP_NOP   = 4'h0,
      OP_SHIN  = 4'h1,
      OP_SEL1  = 4'h2,
      OP_SEL2  = 4'h3,
      OP_CLR   = 4'h4,
      OP_LOAD  = 4'h5,
      OP_STORE = 4'h6,
      OP_MOVTO = 4'h7,
      OP_JMP   = 4'h8,
      OP_JGT   = 4'h9,
      OP_JEQ   = 4'hA,
      OP_MOVFR = 4'hB,
      OP_READ  = 4'hC,
      OP_WRITE = 4'hD,
      OP_CHSEL = 4'hE,
      OP_ALU   = 4'hF
   } opcode_type;

   typedef enum logic [3:0] {
      ALU_ADD = 4'h0,
      ALU_SUB = 4'h1,
      ALU_MUL = 4'h2,
      ALU_DIV = 4'h3,
      ALU_MOD = 4'h4,
      ALU_NOT = 4'h5,
      ALU_AND = 4'h6,
      ALU_OR  = 4'h7,
      ALU_SHL = 4'h8,
      ALU_SAR = 4'h9,
      ALU_C0A = 4'hA,
      ALU_C1B = 4'hB,
      ALU_C0C = 4'hC,
      ALU_C1D = 4'hD,
      ALU_C0E = 4'hE,
      ALU_CMF = 4'hF
   } alu_op_type;

   typedef enum logic [2:0] {
      OUT_OK      = 3'd0,
      OUT_HALT    = 3'd1,
      OUT_ILLEGAL = 3'd2,
      OUT_CLOSED  = 3'd3,
      OUT_STOP    = 3'd4
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_MEMRD,
      ST_DONE
   } state_type;

   localparam logic CSR_SOURCE = 1'b0;
   localparam logic CSR_SINK   = 1'b1;
   localparam logic [3:0] HALT_OPERAND = 4'hF;
   localparam logic [3:0] LINK_REG = 4'hF;

   // divider control from sequencer
   typedef struct packed {
      logic start;
      logic is_mod;
   } div_ctl_type;

   typedef struct packed {
      logic done;
      logic bad;
   } div_sts_type;

endpackage

// ===== rtl/rvm_divider.sv =====
module rvm_divider
   import rvm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  div_ctl_type        ctl,
   input  logic signed [31:0] dividend,
   input  logic signed [31:0] divisor,
   output div_sts_type        sts,
   output logic [31:0]        result
);

   logic        busy_ff, busy_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        nq_ff, nq_in, nr_ff, nr_in, mod_ff, mod_in;
   logic        done_ff, done_in, bad_ff, bad_in;
   logic [32:0] trial;
   logic [31:0] ua, ub;

   // one quotient bit per cycle, restoring division on magnitudes
   always_comb begin
      ua = dividend[31] ? 32'(-dividend) : 32'(dividend);
      ub = divisor[31] ? 32'(-divisor) : 32'(divisor);
      trial = {rem_ff[31:0], quo_ff[31]} - {1'b0, den_ff};
      busy_in = busy_ff; count_in = count_ff; quo_in = quo_ff; rem_in = rem_ff;
      den_in = den_ff; nq_in = nq_ff; nr_in = nr_ff; mod_in = mod_ff;
      done_in = 1'b0; bad_in = bad_ff;
      if (ctl.start) begin
         if (divisor == 32'sd0 || (dividend == 32'sh8000_0000 && divisor == -32'sd1)) begin
            done_in = 1'b1; bad_in = 1'b1; quo_in = '0; rem_in = '0;
            nq_in = 1'b0; nr_in = 1'b0; mod_in = ctl.is_mod;
         end else begin
            busy_in = 1'b1; count_in = '0; bad_in = 1'b0;
            quo_in = ua; rem_in = '0; den_in = ub; mod_in = ctl.is_mod;
            nq_in = dividend[31] ^ divisor[31]; nr_in = dividend[31];
         end
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         count_in = 5'(count_ff + 5'd1);
         if (count_ff == 5'd31) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; bad_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; bad_ff <= bad_in;
      end
      count_ff <= count_in; quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in;
      nq_ff <= nq_in; nr_ff <= nr_in; mod_ff <= mod_in;
   end

   always_comb begin
      sts.done = done_ff;
      sts.bad  = bad_ff;
      if (mod_ff) result = nr_ff ? 32'(-rem_ff[31:0]) : rem_ff[31:0];
      else result = nq_ff ? 32'(-quo_ff) : quo_ff;
   end

`ifndef ASSERT_OFF
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !ctl.start) else $error("divider restarted while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (done_ff && bad_ff) |-> (quo_ff == '0 && rem_ff == '0)) else $error("bad not zero");
`endif

endmodule

// ===== rtl/register_vm_execute_core.sv =====
// Register machine instruction executor.
// req_ channel: one word per instruction: tdata = {sink_reply, read_value,
//   instruction}. rsp_ channel: one word per instruction with next_pc,
//   outcome, stop_value, read/write events, channel and write data.
// csr_ port: index 0 source_attached, index 1 sink_attached; write when idle.
// Sequence: most instructions pass accept (ST_IDLE) then execute (ST_EXEC),
//   with the response registered; loads add ST_MEMRD (registered memory read);
//   divide and modulo wait in ST_DIV (one quotient bit per cycle in the shared
//   divider), skipping the iteration when the divisor is zero or INT_MIN / -1.
// Throughput: one instruction in flight; req_tready is high only when idle
//   and the previous response has been taken.
// Reset: registers, selectors, pc and flags clear; then a clearing pass
//   zeroes every data memory word, during which req_tready stays low.
// A stalled receiver holds the response stable and blocks the next word.
module register_vm_execute_core
   import rvm_pkg::*;
#(
   parameter int MEM_WORDS = 4096,
   parameter int CHANNELS  = 16
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // instruction[7:0], read_value[39:8], sink_reply[47:40]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // next_pc, outcome, stop_value, read_taken,
                                    // write_valid, channel, write_data, pad
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [15:0] CH_MASK = 16'((17'd1 << CHANNELS) - 17'd1);

   state_type state_ff, state_in;
   logic [15:0] src_att_ff, snk_att_ff, exh_ff, exh_in, cls_ff, cls_in;
   logic [31:0] rf_ff [16];
   logic [3:0]  s1_ff, s1_in, s2_ff, s2_in, ch_ff, ch_in;
   logic [31:0] pc_ff, pc_in;
   logic [7:0]  ins_ff;
   logic [31:0] rv_ff;
   logic [7:0]  reply_ff;
   logic [31:0] mem [MEM_WORDS];
   logic [31:0] mem_q_ff;
   logic [AW:0] clr_ff;
   logic        clearing;

   logic        rf_we;
   logic [3:0]  rf_wa;
   logic [31:0] rf_wd;
   logic        lk_we;
   logic        mem_we;
   logic [AW-1:0] mem_wa;
   logic [31:0] mem_wd;
   logic [AW-1:0] mem_ra;

   logic        o_valid_ff, o_valid_in;
   logic [31:0] o_pc_ff, o_pc_in, o_wd_ff, o_wd_in;
   logic [2:0]  o_out_ff, o_out_in;
   logic [7:0]  o_stop_ff, o_stop_in;
   logic        o_rd_ff, o_rd_in, o_wr_ff, o_wr_in;

   div_ctl_type div_ctl;
   div_sts_type div_sts;
   logic [31:0] div_q;

   opcode_type  op;
   alu_op_type  aop;
   logic [3:0]  l;
   logic [31:0] a, b, rl, nxt, alu_r;
   logic [15:0] bit_m;
   logic [31:0] prod;
   logic        take;

   assign clearing = !clr_ff[AW];
   assign op  = opcode_type'(ins_ff[7:4]);
   assign aop = alu_op_type'(ins_ff[3:0]);
   assign l   = ins_ff[3:0];
   assign a   = rf_ff[s1_ff];
   assign b   = rf_ff[s2_ff];
   assign rl  = rf_ff[l];
   assign nxt = 32'(pc_ff + 32'd1);
   assign bit_m = (16'd1 << ch_ff) & CH_MASK;
   assign prod = 32'(a * b);

   rvm_divider u_div (
      .clock(clock), .reset(reset), .ctl(div_ctl), .dividend(a), .divisor(b),
      .sts(div_sts), .result(div_q)
   );

   // shared ALU
   always_comb begin
      unique case (aop)
         ALU_ADD: alu_r = 32'(a + b);
         ALU_SUB: alu_r = 32'(a - b);
         ALU_MUL: alu_r = prod;
         ALU_NOT: alu_r = ~b;
         ALU_AND: alu_r = a & b;
         ALU_OR:  alu_r = a | b;
         ALU_SHL: alu_r = a << b[4:0];
         ALU_SAR: alu_r = 32'($signed(a) >>> b[4:0]);
         ALU_C1B, ALU_C1D: alu_r = 32'd1;
         ALU_CMF: alu_r = 32'hFFFF_FFFF;
         default: alu_r = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      s1_in = s1_ff; s2_in = s2_ff; ch_in = ch_ff; pc_in = pc_ff;
      exh_in = exh_ff; cls_in = cls_ff;
      rf_we = 1'b0; rf_wa = l; rf_wd = '0; lk_we = 1'b0;
      mem_we = 1'b0; mem_wa = b[AW-1:0]; mem_wd = rl; mem_ra = a[AW-1:0];
      div_ctl.start = 1'b0; div_ctl.is_mod = (aop == ALU_MOD);
      o_valid_in = o_valid_ff && !rsp_tready;
      o_pc_in = o_pc_ff; o_out_in = o_out_ff; o_stop_in = o_stop_ff;
      o_rd_in = o_rd_ff; o_wr_in = o_wr_ff; o_wd_in = o_wd_ff;
      take = 1'b0;
      req_tready = (state_ff == ST_IDLE) && !clearing && !o_valid_ff;
      if (clearing) begin
         mem_we = 1'b1; mem_wa = clr_ff[AW-1:0]; mem_wd = '0;
      end
      unique case (state_ff)
         ST_IDLE: if (req_tvalid && req_tready) state_in = ST_EXEC;
         ST_EXEC: begin
            o_pc_in = nxt; o_out_in = OUT_OK; o_stop_in = '0;
            o_rd_in = 1'b0; o_wr_in = 1'b0; o_wd_in = '0;
            state_in = ST_DONE;
            unique case (op)
               OP_NOP: if (l == HALT_OPERAND) o_out_in = OUT_HALT;
               OP_SHIN: begin rf_we = 1'b1; rf_wa = s1_ff; rf_wd = {a[27:0], l}; end
               OP_SEL1: s1_in = l;
               OP_SEL2: s2_in = l;
               OP_CLR: rf_we = 1'b1;
               OP_LOAD: state_in = ST_MEMRD;
               OP_STORE: mem_we = 1'b1;
               OP_MOVTO: begin rf_we = 1'b1; rf_wd = a; end
               OP_JMP, OP_JGT, OP_JEQ: begin
                  if (op == OP_JMP) take = 1'b1;
                  else if (op == OP_JGT) take = $signed(a) > $signed(b);
                  else take = (a == b);
                  if (take) begin
                     lk_we = 1'b1;
                     o_pc_in = (l == LINK_REG) ? nxt : rl;
                  end else o_out_in = OUT_ILLEGAL;
               end
               OP_MOVFR: begin rf_we = 1'b1; rf_wa = s1_ff; rf_wd = rl; end
               OP_READ: begin
                  rf_we = 1'b1;
                  if ((src_att_ff & bit_m) != '0 && (exh_ff & bit_m) == '0) begin
                     rf_wd = rv_ff; o_rd_in = 1'b1;
                     if (rv_ff == 32'hFFFF_FFFF) exh_in = exh_ff | bit_m;
                  end else begin
                     rf_wd = 32'hFFFF_FFFF; o_out_in = OUT_ILLEGAL;
                  end
               end
               OP_WRITE: begin
                  if ((snk_att_ff & bit_m) == '0) o_out_in = OUT_ILLEGAL;
                  else if ((cls_ff & bit_m) != '0) o_out_in = OUT_CLOSED;
                  else begin
                     o_wr_in = 1'b1; o_wd_in = rl;
                     if (rl == 32'hFFFF_FFFF) cls_in = cls_ff | bit_m;
                     if (reply_ff != '0) begin
                        o_out_in = OUT_STOP; o_stop_in = reply_ff;
                     end
                  end
               end
               OP_CHSEL: ch_in = l;
               OP_ALU: begin
                  if (aop == ALU_DIV || aop == ALU_MOD) begin
                     div_ctl.start = 1'b1; state_in = ST_DIV;
                  end else begin
                     rf_we = 1'b1; rf_wa = s1_ff; rf_wd = alu_r;
                  end
               end
               default: ;
            endcase
            if (state_in == ST_DONE) begin
               o_valid_in = 1'b1; pc_in = o_pc_in; state_in = ST_IDLE;
            end
         end
         ST_DIV: if (div_sts.done) begin
            rf_we = 1'b1; rf_wa = s1_ff; rf_wd = div_sts.bad ? '0 : div_q;
            if (div_sts.bad) o_out_in = OUT_ILLEGAL;
            o_valid_in = 1'b1; pc_in = o_pc_ff; state_in = ST_IDLE;
         end
         ST_MEMRD: begin
            rf_we = 1'b1; rf_wd = mem_q_ff;
            o_valid_in = 1'b1; pc_in = o_pc_ff; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; src_att_ff <= 16'd1; snk_att_ff <= 16'd1;
         exh_ff <= '0; cls_ff <= '0; s1_ff <= '0; s2_ff <= '0; ch_ff <= '0;
         pc_ff <= '0; o_valid_ff <= 1'b0; clr_ff <= '0;
         for (int i = 0; i < 16; i++) rf_ff[i] <= '0;
      end else begin
         state_ff <= state_in; exh_ff <= exh_in; cls_ff <= cls_in;
         s1_ff <= s1_in; s2_ff <= s2_in; ch_ff <= ch_in; pc_ff <= pc_in;
         o_valid_ff <= o_valid_in;
         if (clearing) clr_ff <= (AW+1)'(clr_ff + 1'b1);
         if (csr_we) begin
            if (csr_index == CSR_SOURCE) src_att_ff <= csr_wdata;
            else snk_att_ff <= csr_wdata;
         end
         if (lk_we) rf_ff[LINK_REG] <= nxt;
         if (rf_we) rf_ff[rf_wa] <= rf_wd;
      end
      if (req_tvalid && req_tready) begin
         ins_ff <= req_tdata[7:0]; rv_ff <= req_tdata[39:8]; reply_ff <= req_tdata[47:40];
      end
      o_pc_ff <= o_pc_in; o_out_ff <= o_out_in; o_stop_ff <= o_stop_in;
      o_rd_ff <= o_rd_in; o_wr_ff <= o_wr_in; o_wd_ff <= o_wd_in;
   end

   // data memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_q_ff <= mem[mem_ra];
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata = {7'd0, o_wd_ff, ch_ff, o_wr_ff, o_rd_ff, o_stop_ff, o_out_ff, o_pc_ff};

`ifndef ASSERT_OFF
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready) else $error("ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("response dropped");
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready) else $error("accept during clear");
   a_one_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXEC)) else $error("bad start");
`endif

endmodule

// ===== bench/tb.sv =====
module tb;
   import rvm_pkg::*;

   // one executed-instruction result, as carried by rsp_tdata
   typedef struct {
      logic [31:0] next_pc;
      outcome_type outcome;
      logic [7:0]  stop_value;
      logic        read_taken;
      logic        write_valid;
      logic [3:0]  channel;
      logic [31:0] write_data;
   } exec_result_type;

   // directed stimulus row; typed_res used only when has_typed is set
   typedef struct {
      logic [7:0]      instr;
      logic [31:0]     rd_value;
      logic [7:0]      reply;
      bit              has_typed;
      exec_result_type typed_res;
   } stim_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [87:0] rsp_tdata;
   logic        csr_we = 0;
   logic        csr_index = CSR_SOURCE;
   logic [15:0] csr_wdata = '0;

   // machine state copy
   logic [31:0] regs [16];
   logic [31:0] dmem [4096];
   logic [3:0]  sel1, sel2, chan;
   logic [31:0] pc;
   logic [15:0] exhausted, closed;
   logic [15:0] src_att, sink_att;

   exec_result_type pending_results[$];
   int              errors = 0;
   stim_row_type    rows[$];

   register_vm_execute_core dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   initial begin
      #4000000;
      $display("tb: errors");
      $finish;
   end

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   // executes one instruction on the state copy and returns its result
   function automatic exec_result_type execute_instr(logic [7:0] instr, logic [31:0] rv,
                                                     logic [7:0] reply);
      exec_result_type res;
      opcode_type op;
      logic [3:0] l;
      logic [15:0] bitm;
      logic signed [31:0] a, b, r;
      bit take;
      op = opcode_type'(instr[7:4]);
      l = instr[3:0];
      bitm = 16'(1) << chan;
      take = 0;
      res = '{next_pc: 32'(pc + 32'd1), outcome: OUT_OK, stop_value: '0, read_taken: 1'b0,
              write_valid: 1'b0, channel: '0, write_data: '0};
      a = regs[sel1];
      b = regs[sel2];
      case (op)
         OP_NOP: if (l == HALT_OPERAND) res.outcome = OUT_HALT;
         OP_SHIN: regs[sel1] = {regs[sel1][27:0], l};
         OP_SEL1: sel1 = l;
         OP_SEL2: sel2 = l;
         OP_CLR: regs[l] = '0;
         OP_LOAD: regs[l] = dmem[regs[sel1][11:0]];
         OP_STORE: dmem[regs[sel2][11:0]] = regs[l];
         OP_MOVTO: regs[l] = regs[sel1];
         OP_JMP: take = 1;
         OP_JGT: take = a > b;
         OP_JEQ: take = a == b;
         OP_MOVFR: regs[sel1] = regs[l];
         OP_READ: begin
            if ((src_att & bitm) != 0 && (exhausted & bitm) == 0) begin
               regs[l] = rv;
               res.read_taken = 1;
               if (rv == 32'hFFFFFFFF) exhausted |= bitm;
            end else begin
               regs[l] = 32'hFFFFFFFF;
               res.outcome = OUT_ILLEGAL;
            end
         end
         OP_WRITE: begin
            if ((sink_att & bitm) == 0) res.outcome = OUT_ILLEGAL;
            else if ((closed & bitm) != 0) res.outcome = OUT_CLOSED;
            else begin
               res.write_valid = 1;
               res.write_data = regs[l];
               if (regs[l] == 32'hFFFFFFFF) closed |= bitm;
               if (reply != 0) begin
                  res.outcome = OUT_STOP;
                  res.stop_value = reply;
               end
            end
         end
         OP_CHSEL: chan = l;
         default: begin
            r = '0;
            case (alu_op_type'(l))
               ALU_ADD: r = a + b;
               ALU_SUB: r = a - b;
               ALU_MUL: r = a * b;
               ALU_DIV, ALU_MOD: begin
                  if (b == 0 || (a == 32'sh80000000 && b == -32'sd1))
                     res.outcome = OUT_ILLEGAL;
                  else if (alu_op_type'(l) == ALU_DIV) r = a / b;
                  else r = a % b;
               end
               ALU_NOT: r = ~b;
               ALU_AND: r = a & b;
               ALU_OR:  r = a | b;
               ALU_SHL: r = a << b[4:0];
               ALU_SAR: r = a >>> b[4:0];
               ALU_C1B, ALU_C1D: r = 32'sd1;
               ALU_CMF: r = '1;
               default: r = '0;
            endcase
            regs[sel1] = r;
         end
      endcase
      if (op == OP_JMP || op == OP_JGT || op == OP_JEQ) begin
         if (take) begin
            regs[LINK_REG] = res.next_pc;
            res.next_pc = regs[l];
         end else res.outcome = OUT_ILLEGAL;
      end
      pc = res.next_pc;
      res.channel = chan;
      return res;
   endfunction

   // drive one instruction word; valid stays high when the next gap is zero
   task automatic send_word(logic [7:0] instr, logic [31:0] rv, logic [7:0] reply,
                            bit use_typed, exec_result_type typed, int gap_after);
      exec_result_type res;
      req_tvalid <= 1;
      req_tdata <= {reply, rv, instr};
      do @(posedge clock); while (!req_tready);
      res = execute_instr(instr, rv, reply);
      pending_results.push_back(use_typed ? typed : res);
      if (gap_after != 0) req_tvalid <= 0;
      repeat (gap_after) @(posedge clock);
   endtask

   // the last word may have left valid high; drop it before waiting
   task automatic write_csr(logic idx, logic [15:0] val);
      req_tvalid <= 0;
      wait (pending_results.size() == 0);
      repeat (40) @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx == CSR_SOURCE) src_att = val;
      else sink_att = val;
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 7))
         0: return 32'hFFFFFFFF;
         1: return 32'h80000000;
         2: return 32'h7FFFFFFF;
         3: return $urandom_range(0, 20);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] random_instr();
      logic [3:0] op;
      op = 4'($urandom_range(0, 15));
      // favor reads and ALU work so registers carry varied data
      if ($urandom_range(0, 3) == 0) op = $urandom_range(0, 1) ? OP_READ : OP_ALU;
      return {op, 4'($urandom_range(0, 15))};
   endfunction

   // response side: random stalls, field-by-field check
   initial begin
      exec_result_type want;
      logic [87:0] d;
      int stall;
      @(negedge reset);
      forever begin
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         d = rsp_tdata;
         if (pending_results.size() == 0) begin
            report("unexpected word", d[31:0], '0);
         end else begin
            want = pending_results.pop_front();
            if (d[31:0] != want.next_pc) report("next_pc", d[31:0], want.next_pc);
            if (d[34:32] != want.outcome) report("outcome", d[34:32], want.outcome);
            if (d[42:35] != want.stop_value) report("stop_value", d[42:35], want.stop_value);
            if (d[43] != want.read_taken) report("read_taken", d[43], want.read_taken);
            if (d[44] != want.write_valid) report("write_valid", d[44], want.write_valid);
            if (d[48:45] != want.channel) report("channel", d[48:45], want.channel);
            if (d[80:49] != want.write_data) report("write_data", d[80:49], want.write_data);
         end
         stall = $urandom_range(0, 16);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall != 0) begin
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // stimulus
   initial begin
      exec_result_type none;
      logic [15:0] cfg_vals [6];
      int gap;
      none = '{default: 0, outcome: OUT_OK};
      for (int i = 0; i < 16; i++) regs[i] = 0;
      for (int i = 0; i < 4096; i++) dmem[i] = 0;
      sel1 = 0; sel2 = 0; chan = 0; pc = 0;
      exhausted = 0; closed = 0;
      src_att = 1; sink_att = 1;

      // directed rows; the first four results are typed in from reset state
      rows.push_back('{8'h00, 0, 0, 1, '{1, OUT_OK, 0, 0, 0, 0, 0}});
      rows.push_back('{8'h0F, 0, 0, 1, '{2, OUT_HALT, 0, 0, 0, 0, 0}});
      rows.push_back('{8'hF3, 0, 0, 1, '{3, OUT_ILLEGAL, 0, 0, 0, 0, 0}});
      rows.push_back('{8'h90, 0, 0, 1, '{4, OUT_ILLEGAL, 0, 0, 0, 0, 0}});
      rows.push_back('{8'hC1, 32'h80000000, 0, 0, none});  // R1 = INT_MIN
      rows.push_back('{8'hC2, 32'hFFFFFFFF, 8'hFF, 0, none}); // source ends
      rows.push_back('{8'hC3, 32'h7FFFFFFF, 0, 0, none});   // exhausted read
      rows.push_back('{8'h21, 0, 0, 0, none});
      rows.push_back('{8'h32, 0, 0, 0, none});
      rows.push_back('{8'hF3, 0, 0, 0, none});              // INT_MIN / -1
      rows.push_back('{8'h1F, 0, 0, 0, none});              // shift in
      rows.push_back('{8'hF9, 0, 0, 0, none});              // arithmetic shift
      rows.push_back('{8'hD1, 0, 8'h01, 0, none});          // write, sink stop
      rows.push_back('{8'hD2, 0, 0, 0, none});              // write -1 closes
      rows.push_back('{8'hD1, 0, 0, 0, none});              // closed sink
      rows.push_back('{8'h62, 0, 0, 0, none});              // store
      rows.push_back('{8'h53, 0, 0, 0, none});              // load
      rows.push_back('{8'hA1, 0, 0, 0, none});              // equal branch
      rows.push_back('{8'h8F, 0, 0, 0, none});              // jump through link
      rows.push_back('{8'hEF, 0, 0, 0, none});
      rows.push_back('{8'hC4, 0, 0, 0, none});              // no source
      rows.push_back('{8'hD4, 0, 0, 0, none});              // no sink
      rows.push_back('{8'hFF, 0, 0, 0, none});
      rows.push_back('{8'hB5, 0, 0, 0, none});
      rows.push_back('{8'h7A, 0, 0, 0, none});

      repeat (10) @(posedge clock);
      reset <= 0;
      foreach (rows[i])
         send_word(rows[i].instr, rows[i].rd_value, rows[i].reply,
                   rows[i].has_typed, rows[i].typed_res, $urandom_range(0, 16));

      cfg_vals = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h0001, 16'h8000, 16'($urandom)};
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_SOURCE, cfg_vals[ph]);
         write_csr(CSR_SINK, cfg_vals[(ph + 2) % 6] ^ 16'(ph));
         for (int n = 0; n < 325; n++) begin
            gap = $urandom_range(0, 16);
            if (n % 60 < 15) gap = 0;
            send_word(random_instr(), random_value(),
                      $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h00, 0, none,
                      (ph == 5 && n == 324) ? 1 : gap);
         end
      end

      wait (pending_results.size() == 0);
      repeat (60) @(posedge clock);
      if (errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end
endmodule
